/* rtl/fbds_pkg.sv */
`default_nettype none

package fbds_pkg;

    // Field widths
    localparam int CLK_W  = 32;
    localparam int BAUD_W = 24;
    localparam int CD_W   = 30;
    localparam int FP_W   = 3;
    localparam int ERR_W  = 33;

    // Fraction index width, wide enough for up to sixteen steps
    localparam int FPI_W  = 4;

    // Internal arithmetic widths
    localparam int QW     = CLK_W - 3;
    localparam int REM_W  = BAUD_W;
    localparam int PROD_W = 36;
    localparam int VAL_W  = 38;

    localparam logic [CLK_W-1:0] CLOCK_RESET = 32'd32000000;
    localparam int FRACTION_STEPS_DEF = 8;

    // Trial after offset, before the absolute error is taken
    typedef struct packed {
        logic [VAL_W-1:0] val;
        logic [CD_W-1:0]  cd;
        logic [FPI_W-1:0] fp;
        logic             ovs;
        logic             ok;
    } trial_t;

    // Scored candidate
    typedef struct packed {
        logic [VAL_W-1:0] err;
        logic [CD_W-1:0]  cd;
        logic [FPI_W-1:0] fp;
        logic             ovs;
    } cand_t;

    // Entries left at one level of a pairwise reduction
    function automatic int lvl_size(input int n, input int lvl);
        return (n + (1 << lvl) - 1) >> lvl;
    endfunction

endpackage

`default_nettype wire

/* rtl/fractional_baud_divisor_search_top.sv */
// Fractional baud divisor search.
// Write the peripheral clock in hertz on the cfg channel (valid/ready, always
// ready) while no request is in flight. Send a requested baud rate as one beat
// on the in channel (in_valid/in_stall). One result beat comes back on the
// out channel (out_valid/out_stall): the divider, the fraction in eighths, the
// oversampling mode (0 = 16x, 1 = 8x) and the error in clock ticks.
// A new request is taken every cycle unless a held output beat stalls the
// pipeline. The pipeline is one input stage, 29 restoring divider stages (one
// quotient bit each), one multiply stage, two scoring stages and a registered
// minimum tree over all trials, then the output register.
// When out_stall is high with a beat waiting, the whole pipeline holds and
// in_stall rises in the same cycle; nothing is lost or repeated.
// Reset empties the pipeline and loads the clock register with 32 MHz.
// A zero baud rate returns divider 0, fraction 0, 16x, error = clock.
`default_nettype none

module fractional_baud_divisor_search_top
#(
    parameter int FRACTION_STEPS = fbds_pkg::FRACTION_STEPS_DEF
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [fbds_pkg::CLK_W-1:0]  cfg_data,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [fbds_pkg::BAUD_W-1:0] req_baud,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [fbds_pkg::CD_W-1:0]        clock_divider,
    output logic [fbds_pkg::FP_W-1:0]        fractional_part,
    output logic                             oversample_8x,
    output logic [fbds_pkg::ERR_W-1:0]       error_ticks
);
    import fbds_pkg::*;

    localparam int NC = 1 + 6 * FRACTION_STEPS;
    localparam int LV = $clog2(NC);

    logic [CLK_W-1:0] clock_reg;
    logic             adv;

    // Configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_reg <= CLOCK_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            clock_reg <= cfg_data;
        end
    end

    // Advance the whole pipeline unless a finished beat is held
    assign adv      = !out_valid || !out_stall;
    assign in_stall = !adv;

    // Divider stages, index 0 is the input register
    logic              dv_v_reg   [0:QW];
    logic              dv_z_reg   [0:QW];
    logic [BAUD_W-1:0] dv_b_reg   [0:QW];
    logic [REM_W-1:0]  dv_rem_reg [0:QW];
    logic [QW-1:0]     dv_acc_reg [0:QW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_v_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            dv_v_reg[0] <= in_valid;
        end
    end

    // Capture the request; the divide by eight comes from dropping clock bits
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_z_reg[0]   <= (req_baud == '0);
            dv_b_reg[0]   <= req_baud;
            dv_rem_reg[0] <= '0;
            dv_acc_reg[0] <= clock_reg[CLK_W-1:3];
        end
    end

    genvar s;
    generate
        for (s = 0; s < QW; s++)
        begin : g_div
            logic [REM_W:0]   t;
            logic             ge;
            logic [REM_W-1:0] rem_next;

            // Shift in one dividend bit, subtract when it fits
            always_comb
            begin
                t        = {dv_rem_reg[s], dv_acc_reg[s][QW-1]};
                ge       = (t >= {1'b0, dv_b_reg[s]});
                rem_next = ge ? REM_W'(t - {1'b0, dv_b_reg[s]}) : t[REM_W-1:0];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    dv_v_reg[s+1] <= 1'b0;
                end
                else if (adv)
                begin
                    dv_v_reg[s+1] <= dv_v_reg[s];
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    dv_z_reg[s+1]   <= dv_z_reg[s];
                    dv_b_reg[s+1]   <= dv_b_reg[s];
                    dv_rem_reg[s+1] <= rem_next;
                    dv_acc_reg[s+1] <= {dv_acc_reg[s][QW-2:0], ge};
                end
            end
        end
    endgenerate

    // Multiply stage: q*baud for both modes
    logic              mu_v_reg;
    logic              mu_z_reg;
    logic [BAUD_W-1:0] mu_b_reg;
    logic [QW-1:0]     mu_q8_reg;
    logic [QW-1:0]     mu_q16_reg;
    logic [PROD_W-1:0] mu_p8_reg;
    logic [PROD_W-1:0] mu_p16_reg;
    logic [QW-1:0]     q8;
    logic [QW-1:0]     q16;

    assign q8  = dv_acc_reg[QW];
    assign q16 = {1'b0, q8[QW-1:1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mu_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            mu_v_reg <= dv_v_reg[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mu_z_reg   <= dv_z_reg[QW];
            mu_b_reg   <= dv_b_reg[QW];
            mu_q8_reg  <= q8;
            mu_q16_reg <= q16;
            mu_p8_reg  <= PROD_W'(q8 * dv_b_reg[QW]);
            mu_p16_reg <= PROD_W'(q16 * dv_b_reg[QW]);
        end
    end

    // Trial values: base of the middle divider plus small multiples of baud
    logic [VAL_W-1:0] base16;
    logic [VAL_W-1:0] base8;
    logic [VAL_W-1:0] b_ext;
    logic [VAL_W-1:0] clk_ext;

    assign base16  = VAL_W'({mu_p16_reg, 4'b0000});
    assign base8   = VAL_W'({mu_p8_reg, 3'b000});
    assign b_ext   = VAL_W'(mu_b_reg);
    assign clk_ext = VAL_W'(clock_reg);

    logic   t1_v_reg;
    logic   t1_z_reg;
    trial_t t1_reg [0:NC-1];
    cand_t  tr_reg [0:LV][0:NC-1];
    logic   tv_reg [0:LV];
    logic   tz_reg [0:LV];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_v_reg  <= 1'b0;
            tv_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            t1_v_reg  <= mu_v_reg;
            tv_reg[0] <= t1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t1_z_reg  <= mu_z_reg;
            tz_reg[0] <= t1_z_reg;
        end
    end

    genvar c;
    generate
        for (c = 0; c < NC; c++)
        begin : g_cand
            // Entry zero is the seed trial: middle divider, fraction 0, 16x
            localparam int IDX = (c == 0) ? 0 : c - 1;
            localparam int MD  = (c == 0) ? 0 : IDX / (3 * FRACTION_STEPS);
            localparam int JJ  = (c == 0) ? 1 : (IDX % (3 * FRACTION_STEPS)) / FRACTION_STEPS;
            localparam int FPV = (c == 0) ? 0 : IDX % FRACTION_STEPS;
            localparam int KK  = (MD == 1) ? 1 : 2;
            localparam int OFF = KK * FPV + JJ * 8 * KK;
            localparam int SUB = 8 * KK;

            logic [QW-1:0]    q;
            logic [VAL_W-1:0] err;

            assign q = (MD == 1) ? mu_q8_reg : mu_q16_reg;

            // Build the trial product
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    t1_reg[c].val <= ((MD == 1) ? base8 : base16)
                                     + VAL_W'(OFF) * b_ext - VAL_W'(SUB) * b_ext;
                    t1_reg[c].cd  <= CD_W'(q) + CD_W'(JJ) - CD_W'(1);
                    t1_reg[c].fp  <= FPI_W'(FPV);
                    t1_reg[c].ovs <= (MD == 1);
                    t1_reg[c].ok  <= !((JJ == 0) && (q == '0));
                end
            end

            // Score it; a skipped trial never wins
            assign err = (t1_reg[c].val >= clk_ext) ? t1_reg[c].val - clk_ext
                                                    : clk_ext - t1_reg[c].val;

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    tr_reg[0][c].err <= t1_reg[c].ok ? err : '1;
                    tr_reg[0][c].cd  <= t1_reg[c].cd;
                    tr_reg[0][c].fp  <= t1_reg[c].fp;
                    tr_reg[0][c].ovs <= t1_reg[c].ovs;
                end
            end
        end
    endgenerate

    // Minimum tree; on equal error the earlier entry wins
    genvar l, i;
    generate
        for (l = 1; l <= LV; l++)
        begin : g_lvl
            localparam int NS = lvl_size(NC, l - 1);
            localparam int ND = lvl_size(NC, l);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    tv_reg[l] <= 1'b0;
                end
                else if (adv)
                begin
                    tv_reg[l] <= tv_reg[l-1];
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    tz_reg[l] <= tz_reg[l-1];
                end
            end

            for (i = 0; i < ND; i++)
            begin : g_node
                if (2 * i + 1 < NS)
                begin : g_pair
                    always_ff @(posedge clk)
                    begin
                        if (adv)
                        begin
                            if (tr_reg[l-1][2*i+1].err < tr_reg[l-1][2*i].err)
                            begin
                                tr_reg[l][i] <= tr_reg[l-1][2*i+1];
                            end
                            else
                            begin
                                tr_reg[l][i] <= tr_reg[l-1][2*i];
                            end
                        end
                    end
                end
                else
                begin : g_pass
                    always_ff @(posedge clk)
                    begin
                        if (adv)
                        begin
                            tr_reg[l][i] <= tr_reg[l-1][2*i];
                        end
                    end
                end
            end
        end
    endgenerate

    // Output register
    logic             out_v_reg;
    logic [CD_W-1:0]  out_cd_reg;
    logic [FP_W-1:0]  out_fp_reg;
    logic             out_ovs_reg;
    logic [ERR_W-1:0] out_err_reg;
    cand_t            root;

    assign root = tr_reg[LV][0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_v_reg <= tv_reg[LV];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (tz_reg[LV])
            begin
                out_cd_reg  <= '0;
                out_fp_reg  <= '0;
                out_ovs_reg <= 1'b0;
                out_err_reg <= ERR_W'(clock_reg);
            end
            else
            begin
                out_cd_reg  <= root.cd;
                out_fp_reg  <= root.fp[FP_W-1:0];
                out_ovs_reg <= root.ovs;
                out_err_reg <= root.err[ERR_W-1:0];
            end
        end
    end

    assign out_valid       = out_v_reg;
    assign clock_divider   = out_cd_reg;
    assign fractional_part = out_fp_reg;
    assign oversample_8x   = out_ovs_reg;
    assign error_ticks     = out_err_reg;

    // Checks
    a_root_scored: assert property (@(posedge clk) disable iff (!rst_n)
        tv_reg[LV] && !tz_reg[LV] |-> root.err != '1)
        else $error("winning trial is a skipped one");

    a_rem_below_baud: assert property (@(posedge clk) disable iff (!rst_n)
        dv_v_reg[QW] && !dv_z_reg[QW] |-> dv_rem_reg[QW] < dv_b_reg[QW])
        else $error("divider remainder not below baud");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with no held output beat");

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
    import fbds_pkg::*;

    localparam int FRAC_STEPS = 8;
    localparam int LATENCY = 40;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [CD_W-1:0]  cd;
        logic [FP_W-1:0]  fp;
        logic             ovs;
        logic [ERR_W-1:0] err;
    } divisor_t;

    typedef struct {
        logic [BAUD_W-1:0] baud;
        bit                typed;
        divisor_t          res;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CLK_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [BAUD_W-1:0] req_baud = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [CD_W-1:0] clock_divider;
    logic [FP_W-1:0] fractional_part;
    logic oversample_8x;
    logic [ERR_W-1:0] error_ticks;

    logic [CLK_W-1:0] clk_hz_model;
    divisor_t pending_divisors[$];
    int mismatches = 0;
    int cycles = 0;
    bit quiet = 1'b0;
    bit long_hold = 1'b0;

    fractional_baud_divisor_search_top dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .req_baud(req_baud),
        .out_valid(out_valid), .out_stall(out_stall),
        .clock_divider(clock_divider), .fractional_part(fractional_part),
        .oversample_8x(oversample_8x), .error_ticks(error_ticks)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [63:0] tick_error(input logic [63:0] k, input logic [63:0] cd,
                                              input logic [63:0] fp, input logic [63:0] baud);
        logic [63:0] p;
        p = k * (64'd8 * cd + fp) * baud;
        return (p >= clk_hz_model) ? p - clk_hz_model : clk_hz_model - p;
    endfunction

    // Exhaustive search around the nominal divider for both oversampling modes
    function automatic divisor_t best_divisor(input logic [BAUD_W-1:0] baud);
        divisor_t r;
        logic [63:0] b, best_err, e, k, best_cd, best_fp;
        logic best_ovs;
        longint cd0;
        b = baud;
        best_cd = 0; best_fp = 0; best_ovs = 0;
        if (b == 0)
            best_err = clk_hz_model;
        else
        begin
            best_cd = clk_hz_model / (64'd16 * b);
            best_err = tick_error(2, best_cd, 0, b);
            for (int mode = 0; mode < 2; mode++)
            begin
                k = 2 - mode;
                cd0 = longint'(clk_hz_model / (64'd8 * k * b)) - 1;
                for (longint cd = cd0; cd <= cd0 + 2; cd++)
                begin
                    if (cd < 0)
                        continue;
                    for (int fp = 0; fp < FRAC_STEPS; fp++)
                    begin
                        e = tick_error(k, cd, fp, b);
                        if (e < best_err)
                        begin
                            best_err = e; best_cd = cd; best_fp = fp;
                            best_ovs = mode[0];
                        end
                    end
                end
            end
        end
        r.cd = best_cd[CD_W-1:0];
        r.fp = best_fp[FP_W-1:0];
        r.ovs = best_ovs;
        r.err = best_err[ERR_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
        mismatches++;
    endtask

    // Check each result beat against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_divisors.size() == 0)
                report_mismatch("unexpected beat", 0, 0);
            else
            begin
                divisor_t w;
                w = pending_divisors.pop_front();
                if (clock_divider !== w.cd)
                    report_mismatch("clock_divider", clock_divider, w.cd);
                if (fractional_part !== w.fp)
                    report_mismatch("fractional_part", fractional_part, w.fp);
                if (oversample_8x !== w.ovs)
                    report_mismatch("oversample_8x", oversample_8x, w.ovs);
                if (error_ticks !== w.err)
                    report_mismatch("error_ticks", error_ticks, w.err);
            end
        end
    end

    // Receiver stall: random bursts, one long hold-off on request
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                out_stall <= 1'b1;
                repeat (150) @(negedge clk);
                out_stall <= 1'b0;
                long_hold = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                n = $urandom_range(1, 12);
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Offer one beat and hold it until accepted
    task automatic send_baud(input logic [BAUD_W-1:0] b, input bit typed, input divisor_t w);
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        in_valid <= 1'b1;
        req_baud <= b;
        pending_divisors.push_back(typed ? w : best_divisor(b));
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (pending_divisors.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 5) @(negedge clk);
    endtask

    task automatic write_clock(input logic [CLK_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        clk_hz_model = v;
    endtask

    function automatic logic [BAUD_W-1:0] random_baud();
        case ($urandom_range(0, 4))
            0: return BAUD_W'($urandom_range(1, 255));
            1: return BAUD_W'($urandom_range(1200, 1000000));
            2: return BAUD_W'($urandom());
            3: return BAUD_W'(1) << $urandom_range(0, BAUD_W - 1);
            default: return BAUD_W'($urandom_range(1, 7)) * (BAUD_W'(1) << $urandom_range(0, 20));
        endcase
    endfunction

    initial
    begin
        stim_row_t rows[$];
        divisor_t nil;
        logic [CLK_W-1:0] clock_settings[6];
        nil = '{cd: 0, fp: 0, ovs: 0, err: 0};
        clk_hz_model = CLOCK_RESET;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed table at the reset clock of 32 MHz
        rows.push_back('{0, 1, '{cd: 0, fp: 0, ovs: 0, err: 32000000}});
        rows.push_back('{24'hFFFFFF, 0, nil});
        rows.push_back('{1, 0, nil});
        rows.push_back('{115200, 0, nil});
        rows.push_back('{9600, 0, nil});
        rows.push_back('{2000000, 1, '{cd: 1, fp: 0, ovs: 0, err: 0}});
        rows.push_back('{4000000, 0, nil});
        rows.push_back('{16000000, 0, nil});
        rows.push_back('{24'h555555, 0, nil});
        rows.push_back('{24'hAAAAAA, 0, nil});
        rows.push_back('{3000000, 0, nil});
        rows.push_back('{921600, 0, nil});
        foreach (rows[i])
            send_baud(rows[i].baud, rows[i].typed, rows[i].res);
        drain();

        // Clock extremes
        clock_settings = '{32'd1, 32'hFFFFFFFF, 32'd48000000, 32'd7372800, 32'd100, 32'h80000000};
        foreach (clock_settings[c])
        begin
            write_clock(clock_settings[c]);
            send_baud(0, 1, '{cd: 0, fp: 0, ovs: 0, err: clock_settings[c]});
            send_baud(1, 0, nil);
            send_baud(24'hFFFFFF, 0, nil);
            for (int i = 0; i < 150; i++)
            begin
                if (c == 1 && i == 20)
                    long_hold = 1'b1;
                send_baud(random_baud(), 0, nil);
            end
            if (c == 2)
                drain();
            for (int i = 0; i < 30; i++)
                send_baud(random_baud(), 0, nil);
            drain();
        end

        // Random clock, last part without idling or random receiver stalls
        write_clock($urandom());
        quiet = 1'b1;
        for (int i = 0; i < 100; i++)
            send_baud(random_baud(), 0, nil);
        drain();

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

`default_nettype wire
